// ===== rtl/olst_pkg.sv =====
// ----------------------------------------------------------------------------
// olst_pkg
// Shared codes and types for the ordered list engine and its cells.
// ----------------------------------------------------------------------------
`default_nettype none

package olst_pkg;

  // request kinds
  localparam logic [1:0] KIND_PUSH = 2'd0;
  localparam logic [1:0] KIND_REM  = 2'd1;
  localparam logic [1:0] KIND_INS  = 2'd2;
  localparam logic [1:0] KIND_DUMP = 2'd3;

  // result status codes
  localparam logic [2:0] STAT_DONE      = 3'd0;
  localparam logic [2:0] STAT_NOT_FOUND = 3'd1;
  localparam logic [2:0] STAT_FULL      = 3'd2;
  localparam logic [2:0] STAT_APPENDED  = 3'd3;
  localparam logic [2:0] STAT_EMPTY     = 3'd4;

  // what every cell does in a given cycle
  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_PUSH,   // take left neighbor
    CELL_INS,    // open a gap at the first match (or first free cell)
    CELL_REM,    // close the gap at the first match
    CELL_ROT     // rotate valid entries one place toward the head
  } cell_op_e;

  typedef struct packed {
    cell_op_e           op;
    logic signed [31:0] key;
    logic signed [31:0] item;
  } cell_ctrl_t;

endpackage

`default_nettype wire

// ===== rtl/olst_cell.sv =====
// ----------------------------------------------------------------------------
// olst_cell
// One list entry: value and valid bit, key compare, first-match chain.
// ----------------------------------------------------------------------------
`default_nettype none

module olst_cell import olst_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cell_ctrl_t         ctrl_i,
  input  logic signed [31:0] left_val_i,
  input  logic               left_vld_i,
  input  logic signed [31:0] right_val_i,
  input  logic               right_vld_i,
  input  logic signed [31:0] head_val_i,
  input  logic               found_i,
  output logic signed [31:0] val_o,
  output logic               vld_o,
  output logic               hit_o,
  output logic               found_o
);

  logic signed [31:0] val_q, val_d;
  logic               vld_q, vld_d;
  logic               hit, mark;

  assign hit  = vld_q && (val_q == ctrl_i.key);
  // an insert lands on the first match, else on the first free cell
  assign mark = hit || ((ctrl_i.op == CELL_INS) && !vld_q);

  always_comb begin
    val_d = val_q;
    vld_d = vld_q;
    case (ctrl_i.op)
      CELL_PUSH: begin
        val_d = left_val_i;
        vld_d = left_vld_i;
      end
      CELL_INS: begin
        if (found_i) begin
          val_d = left_val_i;
          vld_d = left_vld_i;
        end else if (mark) begin
          val_d = ctrl_i.item;
          vld_d = 1'b1;
        end
      end
      CELL_REM: begin
        if (found_i || hit) begin
          val_d = right_val_i;
          vld_d = right_vld_i;
        end
      end
      CELL_ROT: begin
        // tail of the valid run wraps the head around
        val_d = right_vld_i ? right_val_i : head_val_i;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

  assign val_o   = val_q;
  assign vld_o   = vld_q;
  assign hit_o   = hit;
  assign found_o = found_i || mark;

endmodule

`default_nettype wire

// ===== rtl/ordered_list_engine.sv =====
// ----------------------------------------------------------------------------
// ordered_list_engine
// Ordered list of signed 32-bit values held in a row of cells.
// ----------------------------------------------------------------------------
// The list lives in a row of CAPACITY cells, head in cell 0. A request is
// registered while idle and executed in the exec state: all cells compare
// the key at once, a first-match chain marks the position, and every cell
// shifts toward its neighbor in that same cycle. A dump sends one entry per
// cycle while the output is not stalled (a single empty status when the
// list is empty): the entries rotate through cell 0 and are back in place
// when the dump ends. A result waiting in the output register holds
// execution until it is taken; the next request is still accepted.
`default_nettype none

module ordered_list_engine import olst_pkg::*; #(
  parameter int CAPACITY = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [1:0]         kind_i,
  input  logic signed [31:0] key_i,
  input  logic signed [31:0] item_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [31:0] value_o,
  output logic [2:0]         status_o,
  output logic [4:0]         count_o,
  output logic               last_o
);

  localparam int CntW = $clog2(CAPACITY + 1);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_EXEC = 1'b1;

  logic               state_q, state_d;
  logic [1:0]         kind_q;
  logic signed [31:0] key_q, item_q;
  logic [CntW-1:0]    cnt_q, cnt_d;
  logic [CntW-1:0]    idx_q, idx_d;

  logic               out_valid_q, out_valid_d;
  logic signed [31:0] res_val_d, res_val_q;
  logic [2:0]         res_stat_d, res_stat_q;
  logic [4:0]         res_cnt_d, res_cnt_q;
  logic               res_last_d, res_last_q;

  cell_ctrl_t         ctrl;
  logic signed [31:0] val [CAPACITY];
  logic               vld [CAPACITY];
  logic               fnd [CAPACITY];
  logic [CAPACITY-1:0] hit_vec;

  logic               in_acc, load_ok, full, any_hit, rem_ok, dump_last;
  logic [CntW-1:0]    cnt_m1;
  logic [31:0]        cnt_ext;

  assign in_stall_o = (state_q != S_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign load_ok    = !out_valid_q || !out_stall_i;
  assign full       = (cnt_q == CntW'(CAPACITY));
  assign any_hit    = |hit_vec;
  assign rem_ok     = fnd[CAPACITY-1];
  assign cnt_m1     = cnt_q - CntW'(1);
  assign dump_last  = (idx_q == cnt_m1);
  assign cnt_ext    = 32'(cnt_d);

  // cell command depends on registered state and the output stall; a remove
  // without a match leaves every cell in place
  always_comb begin
    ctrl.op   = CELL_HOLD;
    ctrl.key  = key_q;
    ctrl.item = item_q;
    if ((state_q == S_EXEC) && load_ok) begin
      unique case (kind_q)
        KIND_PUSH: if (!full) ctrl.op = CELL_PUSH;
        KIND_REM:  ctrl.op = CELL_REM;
        KIND_INS:  if (!full) ctrl.op = CELL_INS;
        KIND_DUMP: if (cnt_q != '0) ctrl.op = CELL_ROT;
        default: ;
      endcase
    end
  end

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    idx_d       = idx_q;
    out_valid_d = out_valid_q;
    res_val_d   = res_val_q;
    res_stat_d  = res_stat_q;
    res_cnt_d   = res_cnt_q;
    res_last_d  = res_last_q;

    if (load_ok) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          state_d = S_EXEC;
          idx_d   = '0;
        end
      end
      S_EXEC: begin
        if (load_ok) begin
          out_valid_d = 1'b1;
          res_val_d   = '0;
          res_stat_d  = STAT_DONE;
          res_last_d  = 1'b1;
          state_d     = S_IDLE;
          unique case (kind_q)
            KIND_PUSH: begin
              if (full) begin
                res_stat_d = STAT_FULL;
              end else begin
                cnt_d   = cnt_q + CntW'(1);
              end
            end
            KIND_REM: begin
              if (rem_ok) begin
                cnt_d   = cnt_m1;
              end else begin
                res_stat_d = STAT_NOT_FOUND;
              end
            end
            KIND_INS: begin
              if (full) begin
                res_stat_d = STAT_FULL;
              end else begin
                cnt_d      = cnt_q + CntW'(1);
                res_stat_d = any_hit ? STAT_DONE : STAT_APPENDED;
              end
            end
            KIND_DUMP: begin
              if (cnt_q == '0) begin
                res_stat_d = STAT_EMPTY;
              end else begin
                res_val_d  = val[0];
                res_last_d = dump_last;
                idx_d      = idx_q + CntW'(1);
                if (!dump_last) begin
                  state_d = S_EXEC;
                end
              end
            end
            default: ;
          endcase
          res_cnt_d = cnt_ext[4:0];
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // cell row
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic signed [31:0] lval, rval;
    logic               lvld, rvld, fin;

    if (g == 0) begin : g_head
      assign lval = item_q;
      assign lvld = 1'b1;
      assign fin  = 1'b0;
    end else begin : g_mid
      assign lval = val[g-1];
      assign lvld = vld[g-1];
      assign fin  = fnd[g-1];
    end

    if (g == CAPACITY - 1) begin : g_tail
      assign rval = '0;
      assign rvld = 1'b0;
    end else begin : g_body
      assign rval = val[g+1];
      assign rvld = vld[g+1];
    end

    olst_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctrl_i      (ctrl),
      .left_val_i  (lval),
      .left_vld_i  (lvld),
      .right_val_i (rval),
      .right_vld_i (rvld),
      .head_val_i  (val[0]),
      .found_i     (fin),
      .val_o       (val[g]),
      .vld_o       (vld[g]),
      .hit_o       (hit_vec[g]),
      .found_o     (fnd[g])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      kind_q <= kind_i;
      key_q  <= key_i;
      item_q <= item_i;
    end
    res_val_q  <= res_val_d;
    res_stat_q <= res_stat_d;
    res_cnt_q  <= res_cnt_d;
    res_last_q <= res_last_d;
  end

  assign out_valid_o = out_valid_q;
  assign value_o     = res_val_q;
  assign status_o    = res_stat_q;
  assign count_o     = res_cnt_q;
  assign last_o      = res_last_q;

endmodule

`default_nettype wire

// ===== rtl/olst_checker.sv =====
// ----------------------------------------------------------------------------
// olst_checker
// Port-level checks for the ordered list engine, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module olst_checker import olst_pkg::*; #(
  parameter int CAPACITY = 16
) (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input logic signed [31:0] value_o,
  input logic [2:0]         status_o,
  input logic [4:0]         count_o,
  input logic               last_o
);

  // a stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(value_o) && $stable(last_o))
    else $error("stalled result changed");

  // only dump entries may be followed by more results of the same item
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !last_o |-> status_o == STAT_DONE)
    else $error("non-final result with non-done status");

  // empty dump: zero value and count, single result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == STAT_EMPTY |-> count_o == 5'd0 && last_o && value_o == 32'sd0)
    else $error("bad empty-list result");

  // a dropped push or insert only happens at capacity
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == STAT_FULL |-> count_o == 5'(CAPACITY))
    else $error("full status with count below capacity");

  // count never exceeds capacity
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (CAPACITY > 31) || (32'(count_o) <= 32'(CAPACITY)))
    else $error("count above capacity");

endmodule

bind ordered_list_engine olst_checker #(.CAPACITY(CAPACITY)) u_olst_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .value_o     (value_o),
  .status_o    (status_o),
  .count_o     (count_o),
  .last_o      (last_o)
);

`default_nettype wire

// ===== verif/ordered_list_engine_tb.sv =====
// ----------------------------------------------------------------------------
// ordered_list_engine_tb
// Self-checking bench for the ordered list engine.
// ----------------------------------------------------------------------------
// Runs push, remove, insert-before and dump requests through the request
// channel. A model of the list inside the bench predicts every result item.
// A checker compares each result item with the oldest prediction. Both
// channels see random idle bursts, except in the last stretch of traffic.
// ----------------------------------------------------------------------------
`default_nettype none

module ordered_list_engine_tb;
  import olst_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CAPACITY = 16;

  typedef struct packed {
    logic signed [31:0] value;
    logic [2:0]         status;
    logic [4:0]         count;
    logic               last;
  } list_result_t;

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_stall_o;
  logic [1:0]         kind_i;
  logic signed [31:0] key_i;
  logic signed [31:0] item_i;
  logic               out_valid_o;
  logic               out_stall_i;
  logic signed [31:0] value_o;
  logic [2:0]         status_o;
  logic [4:0]         count_o;
  logic               last_o;

  // list contents as the bench expects them
  logic signed [31:0] model_list [CAPACITY];
  int                 model_count;
  list_result_t       pending_results [$];
  int                 error_count;
  bit                 idle_enable;

  ordered_list_engine #(
    .CAPACITY(CAPACITY)
  ) uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .kind_i      (kind_i),
    .key_i       (key_i),
    .item_i      (item_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .value_o     (value_o),
    .status_o    (status_o),
    .count_o     (count_o),
    .last_o      (last_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #1_000_000;
    $display("TB_ERROR");
    $finish;
  end

  // ---------------------------------------------------------------- predictor
  function automatic void place_entry(input int pos, input logic signed [31:0] v);
    for (int i = model_count; i > pos; i--) model_list[i] = model_list[i - 1];
    model_list[pos] = v;
    model_count++;
  endfunction

  function automatic void predict_request(input logic [1:0] kind,
                                          input logic signed [31:0] key,
                                          input logic signed [31:0] item);
    int         pos;
    logic [2:0] stat;
    stat = STAT_DONE;
    pos  = model_count;
    for (int i = model_count - 1; i >= 0; i--) begin
      if (model_list[i] == key) pos = i;
    end
    case (kind)
      KIND_PUSH: begin
        if (model_count >= CAPACITY) stat = STAT_FULL;
        else place_entry(0, item);
      end
      KIND_REM: begin
        if (pos >= model_count) begin
          stat = STAT_NOT_FOUND;
        end else begin
          for (int i = pos; i + 1 < model_count; i++) model_list[i] = model_list[i + 1];
          model_count--;
        end
      end
      KIND_INS: begin
        if (model_count >= CAPACITY) begin
          stat = STAT_FULL;
        end else begin
          if (pos >= model_count) stat = STAT_APPENDED;
          place_entry(pos, item);
        end
      end
      default: begin
        if (model_count == 0) begin
          pending_results.push_back('{value: '0, status: STAT_EMPTY, count: 5'd0, last: 1'b1});
        end else begin
          for (int i = 0; i < model_count; i++) begin
            pending_results.push_back('{value: model_list[i], status: STAT_DONE,
                                        count: 5'(model_count),
                                        last: (i + 1 == model_count)});
          end
        end
        return;
      end
    endcase
    pending_results.push_back('{value: '0, status: stat, count: 5'(model_count),
                                last: 1'b1});
  endfunction

  // ---------------------------------------------------------------- stimulus
  function automatic logic signed [31:0] random_value();
    case ($urandom_range(0, 3))
      0:       return $urandom_range(0, 1) ? 32'sh7FFFFFFF : 32'sh80000000;
      1:       return $signed($urandom_range(0, 6)) - 3;
      default: return $urandom;
    endcase
  endfunction

  // mostly keys that hit an entry, so remove and insert-before find work
  function automatic logic signed [31:0] pick_key();
    if (model_count > 0 && $urandom_range(0, 9) < 7)
      return model_list[$urandom_range(0, model_count - 1)];
    return random_value();
  endfunction

  // entered at a rising edge; leaves at the edge that accepted the item
  task automatic send_request(input logic [1:0] kind,
                              input logic signed [31:0] key,
                              input logic signed [31:0] item);
    int gap;
    gap = (idle_enable && $urandom_range(0, 5) == 0) ? $urandom_range(1, 18) : 0;
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    kind_i     <= kind;
    key_i      <= key;
    item_i     <= item;
    do @(posedge clk_i); while (in_stall_o);
    predict_request(kind, key, item);
  endtask

  task automatic release_request();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
  endtask

  task automatic send_random(input bit grow);
    int         pick;
    logic [1:0] kind;
    pick = $urandom_range(0, 99);
    if (grow) kind = (pick < 35) ? KIND_PUSH : (pick < 70) ? KIND_INS :
                     (pick < 85) ? KIND_REM : KIND_DUMP;
    else      kind = (pick < 60) ? KIND_REM : (pick < 70) ? KIND_PUSH :
                     (pick < 80) ? KIND_INS : KIND_DUMP;
    send_request(kind, pick_key(), random_value());
  endtask

  // ---------------------------------------------------------------- tests
  task automatic test_empty_list();
    send_request(KIND_DUMP, 32'sd0, 32'sd0);
    send_request(KIND_REM, 32'sd0, 32'sd0);
    send_request(KIND_INS, 32'sd0, 32'sh7FFFFFFF);  // key absent: append
    send_request(KIND_DUMP, 32'sd0, 32'sd0);
  endtask

  task automatic test_extremes_and_duplicates();
    send_request(KIND_PUSH, 32'sd0, 32'sh80000000);
    send_request(KIND_PUSH, 32'sd0, -32'sd1);
    send_request(KIND_PUSH, 32'sh7FFFFFFF, 32'sd7);
    send_request(KIND_PUSH, -32'sd1, 32'sd7);
    send_request(KIND_INS, 32'sd7, 32'sh7FFFFFFF);  // lands ahead of first 7
    send_request(KIND_REM, 32'sd7, 32'sh80000000);  // only the first 7 goes
    send_request(KIND_INS, 32'sd123, -32'sd1);
    send_request(KIND_DUMP, 32'sh80000000, 32'sh7FFFFFFF);
  endtask

  task automatic test_full_list();
    while (model_count < CAPACITY) send_request(KIND_PUSH, random_value(), random_value());
    send_request(KIND_PUSH, 32'sd0, 32'sd1);
    send_request(KIND_INS, model_list[0], 32'sd2);
    send_request(KIND_DUMP, 32'sd0, 32'sd0);
  endtask

  task automatic test_random_traffic();
    for (int phase = 0; phase < 4; phase++) begin
      for (int n = 0; n < 40; n++) send_random(phase[0]);
    end
  endtask

  task automatic test_drain_pause();
    repeat (5) send_random($urandom_range(0, 1));
    release_request();
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (5) send_random($urandom_range(0, 1));
  endtask

  task automatic test_back_to_back();
    idle_enable = 1'b0;
    repeat (35) send_random($urandom_range(0, 1));
  endtask

  // ---------------------------------------------------------------- checking
  task automatic check_field(input string name, input logic [31:0] exp_v,
                             input logic [31:0] act_v);
    if (act_v !== exp_v) begin
      $display("%0t: %s expected %0h actual %0h", $time, name, exp_v, act_v);
      error_count++;
    end
  endtask

  initial begin : result_checker
    list_result_t exp_r;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && !out_stall_i) begin
        if (pending_results.size() == 0) begin
          $display("%0t: result item with none expected, actual value %0h status %0d",
                   $time, value_o, status_o);
          error_count++;
        end else begin
          exp_r = pending_results.pop_front();
          check_field("value", exp_r.value, value_o);
          check_field("status", 32'(exp_r.status), 32'(status_o));
          check_field("count", 32'(exp_r.count), 32'(count_o));
          check_field("last", 32'(exp_r.last), 32'(last_o));
        end
      end
    end
  end

  initial begin : result_stall
    int   stall_left;
    logic stall_next;
    stall_left  = 0;
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (!idle_enable) stall_left = 0;
      if (stall_left > 0) begin
        stall_left--;
        stall_next = 1'b1;
      end else if (idle_enable && $urandom_range(0, 9) == 0) begin
        stall_left = $urandom_range(1, 18) - 1;
        stall_next = 1'b1;
      end else begin
        stall_next = 1'b0;
      end
      out_stall_i <= stall_next;
    end
  end

  // ---------------------------------------------------------------- sequence
  initial begin
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    kind_i      = KIND_PUSH;
    key_i       = '0;
    item_i      = '0;
    model_count = 0;
    error_count = 0;
    idle_enable = 1'b1;
    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_empty_list();
    test_extremes_and_duplicates();
    test_full_list();
    test_random_traffic();
    test_drain_pause();
    test_back_to_back();

    release_request();
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    if (error_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== ordered_list_engine.f =====
rtl/olst_pkg.sv
rtl/olst_cell.sv
rtl/ordered_list_engine.sv
rtl/olst_checker.sv
verif/ordered_list_engine_tb.sv
